// File: design/sde_pkg.sv
// Package for the servo drive enable sequencer.
// Holds sizes, status/control word codes, register indexes and shared types.
// No dependencies.
package sde_pkg;

    localparam int NUM_DRIVES  = 8;
    localparam int DRIVE_W     = 3;
    localparam int DRIVE_SEL_W = $clog2(NUM_DRIVES);

    localparam int STATUS_W = 16;
    localparam int POS_W    = 32;
    localparam int WKC_W    = 16;
    localparam int MODE_W   = 3;
    localparam int HOLD_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Status word bits and masked codes
    localparam logic [STATUS_W-1:0] SW_FAULT = 16'h0008;
    localparam logic [STATUS_W-1:0] SW_SOD   = 16'h0040;
    localparam logic [STATUS_W-1:0] SW_MASK  = 16'h003F;
    localparam logic [STATUS_W-1:0] SW_READY = 16'h0031;
    localparam logic [STATUS_W-1:0] SW_SWON  = 16'h0033;
    localparam logic [STATUS_W-1:0] SW_OPEN  = 16'h0037;

    // Control words
    localparam logic [STATUS_W-1:0] CW_FAULT_RESET = 16'h0080;
    localparam logic [STATUS_W-1:0] CW_SHUTDOWN    = 16'h0006;
    localparam logic [STATUS_W-1:0] CW_SWITCH_ON   = 16'h0007;
    localparam logic [STATUS_W-1:0] CW_ENABLE      = 16'h000F;

    localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd100;

    // Control modes
    localparam logic [MODE_W-1:0] MODE_UNDEF      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_EFFORT     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_VELOCITY   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POSITION   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QUICK_STOP = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_WKC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_CYCLES  = 2'd2;

    typedef struct packed {
        logic [WKC_W-1:0]  expected_wkc;
        logic [MODE_W-1:0] control_mode;
        logic [HOLD_W-1:0] hold_cycles;
    } cfg_t;

    typedef struct packed {
        logic [HOLD_W-1:0]          hold;
        logic [STATUS_W-1:0]        control_word;
        logic signed [POS_W-1:0]    target;
    } entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0]        status_word;
        logic signed [POS_W-1:0]    actual_position;
        logic [WKC_W-1:0]           working_counter;
        logic                       effort_valid;
        logic                       velocity_valid;
        logic                       position_valid;
        logic signed [POS_W-1:0]    position_command;
    } request_t;

endpackage

// File: design/sde_decode.sv
// Per-drive transition logic: next hold count, control word and target.
// Combinational; depends on sde_pkg.
module sde_decode (
    input  sde_pkg::cfg_t     cfg,
    input  sde_pkg::entry_t   cur,
    input  sde_pkg::request_t req,
    output sde_pkg::entry_t   nxt,
    output logic              set_normal
);

    logic [sde_pkg::STATUS_W-1:0] sw_low;
    logic                         wkc_ok;

    assign sw_low = req.status_word & sde_pkg::SW_MASK;
    assign wkc_ok = (req.working_counter >= cfg.expected_wkc);

    always_comb
    begin
        nxt        = cur;
        set_normal = 1'b0;
        if (wkc_ok)
        begin
            if (cur.hold != '0)
            begin
                nxt.hold = cur.hold - 1'b1;
            end
            else if ((req.status_word & sde_pkg::SW_FAULT) != '0)
            begin
                nxt.control_word = sde_pkg::CW_FAULT_RESET;
                nxt.hold         = cfg.hold_cycles;
            end
            else if ((req.status_word & sde_pkg::SW_SOD) != '0)
            begin
                nxt.control_word = sde_pkg::CW_SHUTDOWN;
                nxt.hold         = cfg.hold_cycles;
            end
            else if (sw_low == sde_pkg::SW_READY)
            begin
                nxt.control_word = sde_pkg::CW_SWITCH_ON;
                nxt.hold         = cfg.hold_cycles;
            end
            else if (sw_low == sde_pkg::SW_SWON)
            begin
                // latch actual position so enabling does not jump
                nxt.control_word = sde_pkg::CW_ENABLE;
                nxt.target       = req.actual_position;
                nxt.hold         = cfg.hold_cycles;
            end
            else if (sw_low == sde_pkg::SW_OPEN)
            begin
                set_normal = 1'b1;
                case (cfg.control_mode)
                    sde_pkg::MODE_EFFORT:
                    begin
                        if (req.effort_valid)
                            nxt.control_word = sde_pkg::CW_SHUTDOWN;
                    end
                    sde_pkg::MODE_VELOCITY:
                    begin
                        if (req.velocity_valid)
                            nxt.control_word = sde_pkg::CW_SHUTDOWN;
                    end
                    sde_pkg::MODE_POSITION:
                    begin
                        if (req.position_valid)
                        begin
                            nxt.control_word = sde_pkg::CW_ENABLE;
                            nxt.target       = req.position_command;
                        end
                    end
                    default:
                    begin
                        // undefined and quick stop: drop to shutdown
                        nxt.control_word = sde_pkg::CW_SHUTDOWN;
                    end
                endcase
            end
        end
    end

endmodule

// File: design/servo_drive_enable_sequencer.sv
// Servo drive enable sequencer, top level.
// A request is captured in the input register and its result in the result register.
// Throughput: one request per cycle unless the result is stalled; the per-drive table update and
// the decode sit between the input register and the result register.
// Reset: asynchronous, active low; clears per-drive hold counts, control words,
// targets, normal-op and valid flags; hold_cycles resets to 100, other config fields to 0.
module servo_drive_enable_sequencer (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sde_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sde_pkg::CFG_DATA_W-1:0]      cfg_data,
    // request channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [sde_pkg::DRIVE_W-1:0]         drive_index,
    input  logic [sde_pkg::STATUS_W-1:0]        status_word,
    input  logic signed [sde_pkg::POS_W-1:0]    actual_position,
    input  logic [sde_pkg::WKC_W-1:0]           working_counter,
    input  logic                                effort_valid,
    input  logic                                velocity_valid,
    input  logic                                position_valid,
    input  logic signed [sde_pkg::POS_W-1:0]    position_command,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [sde_pkg::DRIVE_W-1:0]         drive_index_out,
    output logic [sde_pkg::STATUS_W-1:0]        control_word,
    output logic signed [sde_pkg::POS_W-1:0]    target_position,
    output logic                                normal_op
);

    sde_pkg::cfg_t     cfg_reg;
    sde_pkg::entry_t   table_reg [sde_pkg::NUM_DRIVES];
    logic              normal_reg;

    logic                          s1_valid_reg;
    logic [sde_pkg::DRIVE_W-1:0]   s1_drive_reg;
    sde_pkg::request_t             s1_req_reg;

    logic                               out_valid_reg;
    logic [sde_pkg::DRIVE_W-1:0]        out_drive_reg;
    logic [sde_pkg::STATUS_W-1:0]       out_cw_reg;
    logic signed [sde_pkg::POS_W-1:0]   out_target_reg;
    logic                               out_normal_reg;

    logic                              accept_in;
    logic                              advance;
    logic                              in_range;
    logic [sde_pkg::DRIVE_SEL_W-1:0]   sel;
    sde_pkg::entry_t                   cur_entry;
    sde_pkg::entry_t                   nxt_entry;
    logic                              set_normal;
    logic                              normal_next;

    assign cfg_ready = 1'b1;

    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && out_valid_reg && out_stall;
    assign accept_in = in_valid && !in_stall;

    assign in_range  = ({1'b0, s1_drive_reg} < (sde_pkg::DRIVE_W + 1)'(sde_pkg::NUM_DRIVES));
    assign sel       = s1_drive_reg[sde_pkg::DRIVE_SEL_W-1:0];
    assign cur_entry = table_reg[sel];

    sde_decode u_decode (
        .cfg        (cfg_reg),
        .cur        (cur_entry),
        .req        (s1_req_reg),
        .nxt        (nxt_entry),
        .set_normal (set_normal)
    );

    assign normal_next = normal_reg || (in_range && set_normal);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_wkc <= '0;
            cfg_reg.control_mode <= sde_pkg::MODE_UNDEF;
            cfg_reg.hold_cycles  <= sde_pkg::HOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sde_pkg::CFG_EXPECTED_WKC: cfg_reg.expected_wkc <= cfg_data;
                sde_pkg::CFG_CONTROL_MODE:
                    cfg_reg.control_mode <= cfg_data[sde_pkg::MODE_W-1:0];
                sde_pkg::CFG_HOLD_CYCLES:
                    cfg_reg.hold_cycles <= cfg_data[sde_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept_in)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            s1_drive_reg                <= drive_index;
            s1_req_reg.status_word      <= status_word;
            s1_req_reg.actual_position  <= actual_position;
            s1_req_reg.working_counter  <= working_counter;
            s1_req_reg.effort_valid     <= effort_valid;
            s1_req_reg.velocity_valid   <= velocity_valid;
            s1_req_reg.position_valid   <= position_valid;
            s1_req_reg.position_command <= position_command;
        end
    end

    // per-drive table and normal-op flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sde_pkg::NUM_DRIVES; i++)
                table_reg[i] <= '0;
            normal_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (in_range)
                table_reg[sel] <= nxt_entry;
            normal_reg <= normal_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_drive_reg  <= s1_drive_reg;
            out_normal_reg <= normal_next;
            if (in_range)
            begin
                out_cw_reg     <= nxt_entry.control_word;
                out_target_reg <= nxt_entry.target;
            end
            else
            begin
                out_cw_reg     <= '0;
                out_target_reg <= '0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign drive_index_out = out_drive_reg;
    assign control_word    = out_cw_reg;
    assign target_position = out_target_reg;
    assign normal_op       = out_normal_reg;

endmodule
